// ===== rtl/tlc_pkg.sv =====
// Shared types, codes and reset values of the two-way traffic light controller.
package tlc_pkg;

    // Phase codes
    localparam logic [2:0] PH_BEGIN = 3'd0;
    localparam logic [2:0] PH_RG    = 3'd1;
    localparam logic [2:0] PH_RY    = 3'd2;
    localparam logic [2:0] PH_GR    = 3'd3;
    localparam logic [2:0] PH_YR    = 3'd4;
    localparam logic [2:0] PH_ER    = 3'd5;
    localparam logic [2:0] PH_EG    = 3'd6;
    localparam logic [2:0] PH_EY    = 3'd7;

    // Lamp color codes
    localparam logic [1:0] C_DARK = 2'd0;
    localparam logic [1:0] C_RED  = 2'd1;
    localparam logic [1:0] C_YEL  = 2'd2;
    localparam logic [1:0] C_GRN  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_TICK_PERIOD   = 3'd0;
    localparam logic [2:0] REG_BLINK_PERIOD  = 3'd1;
    localparam logic [2:0] REG_BLINK_ON      = 3'd2;
    localparam logic [2:0] REG_EDIT_CEIL     = 3'd3;
    localparam logic [2:0] REG_EDIT_FLOOR    = 3'd4;
    localparam logic [2:0] REG_DEF_RED       = 3'd5;
    localparam logic [2:0] REG_DEF_GREEN     = 3'd6;
    localparam logic [2:0] REG_DEF_YELLOW    = 3'd7;

    // Configuration reset values
    localparam logic [7:0] RST_TICK_PERIOD  = 8'd21;
    localparam logic [7:0] RST_BLINK_PERIOD = 8'd20;
    localparam logic [7:0] RST_BLINK_ON     = 8'd10;
    localparam logic [6:0] RST_EDIT_CEIL    = 7'd99;
    localparam logic [6:0] RST_EDIT_FLOOR   = 7'd1;
    localparam logic [6:0] RST_DEF_RED      = 7'd5;
    localparam logic [6:0] RST_DEF_GREEN    = 7'd3;
    localparam logic [6:0] RST_DEF_YELLOW   = 7'd2;

    // Stored durations are seconds minus one.
    localparam logic [6:0] RST_RED_DUR    = 7'd4;
    localparam logic [6:0] RST_GREEN_DUR  = 7'd2;
    localparam logic [6:0] RST_YELLOW_DUR = 7'd1;

    localparam logic [6:0] SHOW_MAX = 7'd99;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [7:0] tick_period;
        logic [7:0] blink_period;
        logic [7:0] blink_on_ticks;
        logic [6:0] edit_ceil;
        logic [6:0] edit_floor;
        logic [6:0] default_red_s;
        logic [6:0] default_green_s;
        logic [6:0] default_yellow_s;
    } t_cfg;

    typedef struct packed {
        logic [1:0] light1_color;
        logic [1:0] light2_color;
        logic [6:0] display1;
        logic [6:0] display2;
        logic       manual_mode;
        logic       timing_error;
        logic [2:0] phase;
    } t_result;

endpackage

// ===== rtl/tlc_cfg_regs.sv =====
// Configuration register file of the traffic light controller.
module tlc_cfg_regs
    import tlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period      <= RST_TICK_PERIOD;
            r_cfg.blink_period     <= RST_BLINK_PERIOD;
            r_cfg.blink_on_ticks   <= RST_BLINK_ON;
            r_cfg.edit_ceil        <= RST_EDIT_CEIL;
            r_cfg.edit_floor       <= RST_EDIT_FLOOR;
            r_cfg.default_red_s    <= RST_DEF_RED;
            r_cfg.default_green_s  <= RST_DEF_GREEN;
            r_cfg.default_yellow_s <= RST_DEF_YELLOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_TICK_PERIOD:  r_cfg.tick_period      <= i_cfg_data;
                REG_BLINK_PERIOD: r_cfg.blink_period     <= i_cfg_data;
                REG_BLINK_ON:     r_cfg.blink_on_ticks   <= i_cfg_data;
                REG_EDIT_CEIL:    r_cfg.edit_ceil        <= i_cfg_data[6:0];
                REG_EDIT_FLOOR:   r_cfg.edit_floor       <= i_cfg_data[6:0];
                REG_DEF_RED:      r_cfg.default_red_s    <= i_cfg_data[6:0];
                REG_DEF_GREEN:    r_cfg.default_green_s  <= i_cfg_data[6:0];
                default:          r_cfg.default_yellow_s <= i_cfg_data[6:0];
            endcase
        end
    end

endmodule

// ===== rtl/tlc_step.sv =====
// Controller state and the single-pass next-state and result logic for one tick.
module tlc_step
    import tlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  logic    i_mode,
    input  logic    i_inc,
    input  logic    i_set,
    output t_result o_result
);

    logic [2:0] r_phase,  n_phase;
    logic [7:0] r_div,    n_div;
    logic [7:0] r_blink,  n_blink;
    logic [7:0] r_cd1,    n_cd1;
    logic [7:0] r_cd2,    n_cd2;
    logic [6:0] r_red,    n_red;
    logic [6:0] r_green,  n_green;
    logic [6:0] r_yellow, n_yellow;
    logic [6:0] r_edit,   n_edit;
    logic       r_manual, n_manual;

    logic [7:0] tp;
    logic [7:0] bp;
    logic [8:0] div_sum;
    logic [8:0] blink_sum;
    logic [7:0] blink_wrap;
    logic       sec;
    logic       run;
    logic [7:0] cd1_dec;
    logic [7:0] cd2_dec;
    logic [6:0] ev_p1;
    logic [6:0] ev_after;
    logic [6:0] dur_set;
    logic [7:0] dur_sum;
    logic       err;
    logic       lit;
    logic [1:0] c1;
    logic [1:0] c2;

    function automatic logic [6:0] show_signed(input logic [7:0] v);
        logic [6:0] res;
        if (v[7]) begin
            res = '0;
        end else if (v[6:0] > SHOW_MAX) begin
            res = SHOW_MAX;
        end else begin
            res = v[6:0];
        end
        return res;
    endfunction

    always_comb begin
        // Periods of zero behave as one.
        tp = (i_cfg.tick_period  == 8'd0) ? 8'd1 : i_cfg.tick_period;
        bp = (i_cfg.blink_period == 8'd0) ? 8'd1 : i_cfg.blink_period;

        div_sum    = {1'b0, r_div} + 9'd1;
        n_div      = (div_sum >= {1'b0, tp}) ? 8'd0 : div_sum[7:0];
        sec        = (n_div >= (tp - 8'd1));
        blink_sum  = {1'b0, r_blink} + 9'd1;
        blink_wrap = (blink_sum >= {1'b0, bp}) ? 8'd0 : blink_sum[7:0];

        run     = (r_phase >= PH_RG) && (r_phase <= PH_YR);
        cd1_dec = (sec && run) ? (r_cd1 - 8'd1) : r_cd1;
        cd2_dec = (sec && run) ? (r_cd2 - 8'd1) : r_cd2;

        // Edit buttons: increment with wrap, then set stores value minus one.
        ev_p1    = r_edit + 7'd1;
        ev_after = i_inc ? ((ev_p1 > i_cfg.edit_ceil) ? i_cfg.edit_floor : ev_p1) : r_edit;
        dur_set  = ev_after - 7'd1;

        dur_sum = {1'b0, r_green} + {1'b0, r_yellow} + 8'd1;

        n_phase  = r_phase;
        n_blink  = blink_wrap;
        n_cd1    = cd1_dec;
        n_cd2    = cd2_dec;
        n_red    = r_red;
        n_green  = r_green;
        n_yellow = r_yellow;
        n_edit   = r_edit;
        n_manual = r_manual;
        err      = 1'b0;

        unique case (r_phase)
            PH_BEGIN: begin
                if ({1'b0, r_red} != dur_sum) begin
                    n_red    = i_cfg.default_red_s - 7'd1;
                    n_green  = i_cfg.default_green_s - 7'd1;
                    n_yellow = i_cfg.default_yellow_s - 7'd1;
                    err      = 1'b1;
                end
                n_phase = PH_RG;
                n_cd1   = {1'b0, n_red};
                n_cd2   = {1'b0, n_green};
            end
            PH_RG, PH_RY, PH_GR, PH_YR: begin
                if (i_mode) begin
                    n_manual = 1'b1;
                    n_edit   = r_red + 7'd1;
                    n_phase  = PH_ER;
                    n_blink  = 8'd0;
                end else if (sec) begin
                    unique case (r_phase)
                        PH_RG: begin
                            if (cd2_dec[7]) begin
                                n_phase = PH_RY;
                                n_cd2   = {1'b0, r_yellow};
                            end
                        end
                        PH_RY: begin
                            if (cd1_dec[7]) begin
                                n_phase = PH_GR;
                                n_cd1   = {1'b0, r_green};
                                n_cd2   = {1'b0, r_red};
                            end
                        end
                        PH_GR: begin
                            if (cd1_dec[7]) begin
                                n_phase = PH_YR;
                                n_cd1   = {1'b0, r_yellow};
                            end
                        end
                        default: begin
                            if (cd2_dec[7]) begin
                                n_phase = PH_RG;
                                n_cd1   = {1'b0, r_red};
                                n_cd2   = {1'b0, r_green};
                            end
                        end
                    endcase
                end
            end
            PH_ER: begin
                n_edit = ev_after;
                if (i_set) begin
                    n_red = dur_set;
                end
                if (i_mode) begin
                    n_phase = PH_EG;
                    n_edit  = r_green + 7'd1;
                    n_blink = 8'd0;
                end
            end
            PH_EG: begin
                n_edit = ev_after;
                if (i_set) begin
                    n_green = dur_set;
                end
                if (i_mode) begin
                    n_phase = PH_EY;
                    n_edit  = r_yellow + 7'd1;
                    n_blink = 8'd0;
                end
            end
            default: begin
                n_edit = ev_after;
                if (i_set) begin
                    n_yellow = dur_set;
                end
                if (i_mode) begin
                    n_manual = 1'b0;
                    n_phase  = PH_BEGIN;
                    n_blink  = 8'd0;
                end
            end
        endcase

        lit = (n_blink < i_cfg.blink_on_ticks);
        unique case (n_phase)
            PH_RG:   begin c1 = C_RED;  c2 = C_GRN;  end
            PH_RY:   begin c1 = C_RED;  c2 = C_YEL;  end
            PH_GR:   begin c1 = C_GRN;  c2 = C_RED;  end
            PH_YR:   begin c1 = C_YEL;  c2 = C_RED;  end
            PH_ER:   begin c1 = lit ? C_RED : C_DARK; c2 = c1; end
            PH_EG:   begin c1 = lit ? C_GRN : C_DARK; c2 = c1; end
            PH_EY:   begin c1 = lit ? C_YEL : C_DARK; c2 = c1; end
            default: begin c1 = C_DARK; c2 = C_DARK; end
        endcase

        o_result.light1_color = c1;
        o_result.light2_color = c2;
        if (n_manual) begin
            o_result.display1 = show_signed({1'b0, n_edit});
            o_result.display2 = show_signed({1'b0, n_edit});
        end else begin
            o_result.display1 = show_signed(n_cd1);
            o_result.display2 = show_signed(n_cd2);
        end
        o_result.manual_mode  = n_manual;
        o_result.timing_error = err;
        o_result.phase        = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BEGIN;
            r_div    <= '0;
            r_blink  <= '0;
            r_cd1    <= '0;
            r_cd2    <= '0;
            r_red    <= RST_RED_DUR;
            r_green  <= RST_GREEN_DUR;
            r_yellow <= RST_YELLOW_DUR;
            r_edit   <= '0;
            r_manual <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_div    <= n_div;
            r_blink  <= n_blink;
            r_cd1    <= n_cd1;
            r_cd2    <= n_cd2;
            r_red    <= n_red;
            r_green  <= n_green;
            r_yellow <= n_yellow;
            r_edit   <= n_edit;
            r_manual <= n_manual;
        end
    end

    // The edit flag is set exactly in the three edit phases.
    a_manual_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_manual == (r_phase >= PH_ER))
        else $error("edit flag disagrees with phase");

    // A tick taken in the begin phase always starts the red/green phase.
    a_begin_to_rg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_BEGIN) |=> (r_phase == PH_RG))
        else $error("begin phase did not start red/green");

    // Countdowns only move when a tick is taken.
    a_cd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_cd1) && $stable(r_cd2) && $stable(r_phase)))
        else $error("state changed without a tick");

endmodule

// ===== rtl/tlc_out_skid.sv =====
// Output register with a skid stage for the result words.
module tlc_out_skid
    import tlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    in_fire;
    logic    out_free;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= i_data;
            end
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

    // The skid stage only fills behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

endmodule

// ===== rtl/two_way_traffic_light_controller_core.sv =====
// Top level of the two-way traffic light controller core.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         tdata: mode_press, inc_press, set_press, zero fill
//  m_axis    out        tdata: light1_color, light2_color, display1, display2,
//                              timing_error, phase, zero fill; tuser: manual_mode
//  cfg       in         i_cfg_addr register index, i_cfg_data value
//
// Each input word is one 50 ms tick. The controller state is updated in the
// same clock edge that accepts the word, and the result word is registered
// into the output stage at that edge. One word can be accepted in every
// cycle while s_axis_tready is high. A two-entry output stage (output
// register plus skid register) keeps s_axis_tready high while a finished
// result waits for m_axis_tready; tready drops only when both entries hold
// words. i_rst_n is synchronous and active low; it restores the state and
// all configuration registers. Configuration writes are always accepted.
module two_way_traffic_light_controller_core
    import tlc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: [0] mode_press, [1] inc_press, [2] set_press, [7:3] zero
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tdata: [1:0] light1_color, [3:2] light2_color, [10:4] display1,
    //        [17:11] display2, [18] timing_error, [21:19] phase, [23:22] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: [0] manual_mode
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_addr,
    input  logic [7:0]             i_cfg_data
);

    t_cfg    cfg;
    t_result step_result;
    t_result out_result;
    logic    in_fire;

    // A tick word is taken whenever the output stage has room.
    assign in_fire = s_axis_tvalid && s_axis_tready;

    tlc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Controller state and the whole per-tick update.
    tlc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (in_fire),
        .i_mode   (s_axis_tdata[0]),
        .i_inc    (s_axis_tdata[1]),
        .i_set    (s_axis_tdata[2]),
        .o_result (step_result)
    );

    tlc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (step_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    // Pack the result word; the edit flag travels on tuser.
    assign m_axis_tdata = {2'b00,
                           out_result.phase,
                           out_result.timing_error,
                           out_result.display2,
                           out_result.display1,
                           out_result.light2_color,
                           out_result.light1_color};
    assign m_axis_tuser = out_result.manual_mode;

endmodule
